/* design/assert_macros.svh */
// Assertion macros used by the parser (dqc_parser).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/dqc_pkg.sv */
`default_nettype none

package dqc_pkg;

  // Default bound on the query name length.
  localparam int DEF_MAX_NAME_BYTES = 256;

  // Fixed byte positions in the frame.
  localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
  localparam logic [15:0] POS_ETYPE_END = 16'd13;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_IP_END    = 16'd33;
  localparam logic [15:0] POS_PORT_HI   = 16'd36;
  localparam logic [15:0] POS_PORT_LO   = 16'd37;
  localparam logic [15:0] POS_UDP_END   = 16'd41;
  localparam logic [15:0] POS_ID_HI     = 16'd42;
  localparam logic [15:0] POS_ID_LO     = 16'd43;
  localparam logic [15:0] POS_FLAGS     = 16'd44;
  localparam logic [15:0] POS_DNS_END   = 16'd53;
  localparam logic [15:0] POS_NAME      = 16'd54;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  // Header field values.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  FLAG_MASK      = 8'hF8;
  localparam logic [2:0]  TAIL_BYTES     = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_SERVER_PORT    = 16'd53;
  localparam logic [15:0] RST_TYPE_ADDR4     = 16'd1;
  localparam logic [15:0] RST_TYPE_ADDR6     = 16'd28;
  localparam logic [15:0] RST_CLASS_INTERNET = 16'd1;

  // Register indexes.
  typedef enum logic [1:0] {
    CFG_SERVER_PORT    = 2'd0,
    CFG_TYPE_ADDR4     = 2'd1,
    CFG_TYPE_ADDR6     = 2'd2,
    CFG_CLASS_INTERNET = 2'd3
  } cfg_sel_t;

  // Verdict and fault codes.
  typedef enum logic [2:0] {
    VERDICT_CACHEABLE   = 3'd0,
    VERDICT_TRUNCATED   = 3'd1,
    VERDICT_NOT_DNS     = 3'd2,
    VERDICT_NOT_QUERY   = 3'd3,
    VERDICT_NAME_LONG   = 3'd4,
    VERDICT_UNSUPPORTED = 3'd5
  } verdict_t;

  // Result kinds.
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [15:0] server_port;
    logic [15:0] type_addr4;
    logic [15:0] type_addr6;
    logic [15:0] class_internet;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [2:0]  verdict;
    logic [15:0] txn_id;
    logic [15:0] query_type;
    logic [8:0]  name_len;
  } res_t;

endpackage

`default_nettype wire

/* design/dqc_in_if.sv */
`default_nettype none

// Request channel carrying frame bytes.
interface dqc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

/* design/dqc_out_if.sv */
`default_nettype none

// Result channel carrying name bytes and verdicts.
interface dqc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_byte;
  logic [2:0]  verdict;
  logic [15:0] txn_id;
  logic [15:0] query_type;
  logic [8:0]  name_len;

  modport source (output valid, output kind, output name_byte, output verdict,
                  output txn_id, output query_type, output name_len, input ready);
  modport sink (input valid, input kind, input name_byte, input verdict,
                input txn_id, input query_type, input name_len, output ready);
endinterface

`default_nettype wire

/* design/dns_query_classifier.sv */
// DNS query classifier.
// Frame bytes arrive on the frame channel, one request per byte, with
// end_of_frame set on the last byte. The block assumes Ethernet, a 20-byte
// IPv4 header, UDP and a DNS header at fixed offsets. Each query name byte,
// up to and including the zero terminator, is sent on the result channel
// with kind 0; the last byte of a frame gives one verdict with kind 1,
// carrying the transaction id, qtype and name length.
// A byte accepted into the input register is parsed out of it and its
// result is loaded into the result register; the parse step between those
// two registers is combinational. One byte per cycle is taken while the
// result receiver does not stall. When it stalls, a held result stays in
// the result register, the byte in the input register waits, and
// frame.ready drops. Configuration writes through cfg_we, cfg_index and
// cfg_data take effect on the next edge; the user must make them while no
// frame is in progress, as the block itself does not enforce this.
// Reset (rst, synchronous) empties both registers, clears the frame state
// and loads the register defaults: port 53, qtypes 1 and 28, qclass 1.
`default_nettype none

module dns_query_classifier import dqc_pkg::*; #(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  dqc_in_if.sink           frame,
  dqc_out_if.source        result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     fire;
  logic     free;
  logic     res_valid;
  res_t     res;

  // A held byte is processed whenever the result register can take it.
  assign fire = item_valid && free;

  dqc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dqc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  dqc_parser #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  dqc_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .result (result),
    .load   (fire && res_valid),
    .res    (res),
    .free   (free)
  );

endmodule

`default_nettype wire

/* design/dqc_cfg_regs.sv */
`default_nettype none

module dqc_cfg_regs import dqc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t            cfg
);

  cfg_sel_t sel;
  assign sel = cfg_sel_t'(cfg_index);

  // Register file, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.server_port    <= RST_SERVER_PORT;
      cfg.type_addr4     <= RST_TYPE_ADDR4;
      cfg.type_addr6     <= RST_TYPE_ADDR6;
      cfg.class_internet <= RST_CLASS_INTERNET;
    end else if (cfg_we) begin
      case (sel)
        CFG_SERVER_PORT:    cfg.server_port    <= cfg_data;
        CFG_TYPE_ADDR4:     cfg.type_addr4     <= cfg_data;
        CFG_TYPE_ADDR6:     cfg.type_addr6     <= cfg_data;
        CFG_CLASS_INTERNET: cfg.class_internet <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dqc_in_reg.sv */
`default_nettype none

module dqc_in_reg import dqc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dqc_in_if.sink    frame,
  input  wire logic take,
  output logic      item_valid,
  output in_item_t  item
);

  // Ready whenever the held byte is empty or leaves this cycle.
  assign frame.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (frame.ready) begin
      item_valid <= frame.valid;
    end
  end

  // Byte payload needs no reset.
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      item.frame_byte   <= frame.frame_byte;
      item.end_of_frame <= frame.end_of_frame;
    end
  end

endmodule

`default_nettype wire

/* design/dqc_parser.sv */
`default_nettype none
`include "assert_macros.svh"

module dqc_parser import dqc_pkg::*; #(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic fire,
  input  wire in_item_t item,
  output logic      res_valid,
  output res_t      res
);

  localparam int NCW = $clog2(MAX_NAME_BYTES + 1);
  localparam logic [NCW-1:0] NAME_LIMIT = NCW'(MAX_NAME_BYTES);

  // Frame state.
  logic [15:0]    byte_pos, byte_pos_next;
  verdict_t       fault_code, fault_code_next;
  logic [15:0]    id_hold, id_hold_next;
  logic [NCW-1:0] name_count, name_count_next;
  logic           name_done, name_done_next;
  logic [2:0]     tail_count, tail_count_next;
  logic [15:0]    type_hold, type_hold_next;
  logic [15:0]    class_hold, class_hold_next;
  logic [15:0]    word_hold, word_hold_next;
  logic [7:0]     proto_hold, proto_hold_next;
  logic [7:0]     flag_hold, flag_hold_next;

  logic           emit;
  logic [7:0]     b;
  verdict_t       verdict;
  logic [NCW+8:0] count_ext;

  assign b = item.frame_byte;

  // Field capture, header checks and name walk for the current byte.
  always_comb begin
    byte_pos_next   = byte_pos;
    fault_code_next = fault_code;
    id_hold_next    = id_hold;
    name_count_next = name_count;
    name_done_next  = name_done;
    tail_count_next = tail_count;
    type_hold_next  = type_hold;
    class_hold_next = class_hold;
    word_hold_next  = word_hold;
    proto_hold_next = proto_hold;
    flag_hold_next  = flag_hold;
    emit            = 1'b0;

    if (fault_code == VERDICT_CACHEABLE) begin
      if (byte_pos == POS_ETYPE_HI || byte_pos == POS_PORT_HI) begin
        word_hold_next = {b, 8'd0};
      end else if (byte_pos == POS_ETYPE_END || byte_pos == POS_PORT_LO) begin
        word_hold_next = {word_hold[15:8], word_hold[7:0] | b};
      end else if (byte_pos == POS_PROTO) begin
        proto_hold_next = b;
      end else if (byte_pos == POS_ID_HI) begin
        id_hold_next = {b, 8'd0};
      end else if (byte_pos == POS_ID_LO) begin
        id_hold_next = {id_hold[15:8], id_hold[7:0] | b};
      end else if (byte_pos == POS_FLAGS) begin
        flag_hold_next = b;
      end

      if (byte_pos == POS_ETYPE_END && word_hold_next != ETHERTYPE_IPV4) begin
        fault_code_next = VERDICT_NOT_DNS;
      end else if (byte_pos == POS_IP_END && proto_hold_next != PROTO_UDP) begin
        fault_code_next = VERDICT_NOT_DNS;
      end else if (byte_pos == POS_UDP_END && word_hold_next != cfg.server_port) begin
        fault_code_next = VERDICT_NOT_DNS;
      end else if (byte_pos == POS_DNS_END && (flag_hold_next & FLAG_MASK) != 8'd0) begin
        fault_code_next = VERDICT_NOT_QUERY;
      end else if (byte_pos >= POS_NAME) begin
        if (!name_done) begin
          emit            = 1'b1;
          name_count_next = name_count + NCW'(1);
          if (b == 8'd0) begin
            name_done_next = 1'b1;
          end else if (name_count_next >= NAME_LIMIT) begin
            fault_code_next = VERDICT_NAME_LONG;
          end
        end else if (tail_count < TAIL_BYTES) begin
          case (tail_count)
            3'd0:    type_hold_next  = {b, 8'd0};
            3'd1:    type_hold_next  = {type_hold[15:8], type_hold[7:0] | b};
            3'd2:    class_hold_next = {b, 8'd0};
            default: class_hold_next = {class_hold[15:8], class_hold[7:0] | b};
          endcase
          tail_count_next = tail_count + 3'd1;
        end
      end
    end

    // Position saturates at its maximum.
    if (byte_pos != POS_MAX) begin
      byte_pos_next = byte_pos + 16'd1;
    end
  end

  // Verdict from the state after this byte.
  always_comb begin
    if (fault_code_next != VERDICT_CACHEABLE) begin
      verdict = fault_code_next;
    end else if (tail_count_next < TAIL_BYTES) begin
      verdict = VERDICT_TRUNCATED;
    end else if (type_hold_next != cfg.type_addr4 && type_hold_next != cfg.type_addr6) begin
      verdict = VERDICT_UNSUPPORTED;
    end else if (class_hold_next != cfg.class_internet) begin
      verdict = VERDICT_UNSUPPORTED;
    end else begin
      verdict = VERDICT_CACHEABLE;
    end
  end

  assign count_ext = {9'd0, name_count_next};

  // Result for the byte: a verdict on the final byte, else a name byte.
  always_comb begin
    res_valid = item.end_of_frame || emit;
    if (item.end_of_frame) begin
      res.kind       = KIND_VERDICT;
      res.name_byte  = 8'd0;
      res.verdict    = verdict;
      res.txn_id     = (byte_pos_next > POS_ID_LO) ? id_hold_next : 16'd0;
      res.query_type = (tail_count_next >= 3'd2) ? type_hold_next : 16'd0;
      res.name_len   = name_done_next ? count_ext[8:0] : 9'd0;
    end else begin
      res.kind       = KIND_NAME;
      res.name_byte  = b;
      res.verdict    = VERDICT_CACHEABLE;
      res.txn_id     = 16'd0;
      res.query_type = 16'd0;
      res.name_len   = 9'd0;
    end
  end

  // State update; the final byte returns the frame state to reset.
  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_frame)) begin
      byte_pos   <= 16'd0;
      fault_code <= VERDICT_CACHEABLE;
      id_hold    <= 16'd0;
      name_count <= '0;
      name_done  <= 1'b0;
      tail_count <= 3'd0;
      type_hold  <= 16'd0;
      class_hold <= 16'd0;
      word_hold  <= 16'd0;
      proto_hold <= 8'd0;
      flag_hold  <= 8'd0;
    end else if (fire) begin
      byte_pos   <= byte_pos_next;
      fault_code <= fault_code_next;
      id_hold    <= id_hold_next;
      name_count <= name_count_next;
      name_done  <= name_done_next;
      tail_count <= tail_count_next;
      type_hold  <= type_hold_next;
      class_hold <= class_hold_next;
      word_hold  <= word_hold_next;
      proto_hold <= proto_hold_next;
      flag_hold  <= flag_hold_next;
    end
  end

  // The name count never passes the bound.
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, name_count <= NAME_LIMIT)
  // A terminated name cannot also be too long.
  `ASSERT_IMPL(a_done_not_long, clk, rst, fault_code == VERDICT_NAME_LONG, !name_done)
  // Qtype and qclass bytes are only taken after the terminator.
  `ASSERT_IMPL(a_tail_after_name, clk, rst, tail_count != 3'd0,
               name_done && tail_count <= TAIL_BYTES)
  // A final byte leaves the frame state cleared.
  `ASSERT_NEXT(a_clear_on_last, clk, rst, fire && item.end_of_frame,
               byte_pos == 16'd0 && name_count == '0)

endmodule

`default_nettype wire

/* design/dqc_out_reg.sv */
`default_nettype none

module dqc_out_reg import dqc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  dqc_out_if.source  result,
  input  wire logic  load,
  input  wire res_t  res,
  output logic       free
);

  res_t held;

  // The register can take a new result when empty or being drained.
  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (free) begin
      result.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign result.kind       = held.kind;
  assign result.name_byte  = held.name_byte;
  assign result.verdict    = held.verdict;
  assign result.txn_id     = held.txn_id;
  assign result.query_type = held.query_type;
  assign result.name_len   = held.name_len;

endmodule

`default_nettype wire
